[design/fsk4fb_pkg.sv]
// fsk4fb_pkg: shared constants and word types for the 4FSK frame symbol builder.
// No dependencies; imported by fsk4fb_seq and the top level.
`default_nettype none

package fsk4fb_pkg;

	localparam int MAX_PAYLOAD_BYTES = 32;
	localparam int PREAMBLE_SYMBOLS  = 16;
	localparam int SYNC_SYMBOLS      = 8;

	// symbols held in the sync register; sync positions past this send 0
	localparam int SYNC_REG_SYMS = 8;

	// symbol counter covers the longest header section
	localparam int CNT_W = 6;

	localparam logic [CNT_W-1:0] PRE_LAST    = CNT_W'(PREAMBLE_SYMBOLS - 1);
	localparam logic [CNT_W-1:0] SYNC_LAST   = CNT_W'(SYNC_SYMBOLS - 1);
	localparam logic [CNT_W-1:0] SYNC_IN_REG = CNT_W'(SYNC_REG_SYMS);
	localparam logic [CNT_W-1:0] DIBIT_LAST  = CNT_W'(3);
	localparam logic [7:0]       MAX_LEN     = 8'(MAX_PAYLOAD_BYTES);

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] payload_len;
		logic       first_of_frame;
		logic       last_of_frame;
	} fsk4fb_in_t;

	typedef struct packed {
		logic [1:0] symbol;
		logic       end_of_run;
		logic       length_error;
	} fsk4fb_out_t;

endpackage

`default_nettype wire

[design/fsk4fb_dibit_sel.sv]
// fsk4fb_dibit_sel: shared dibit extraction unit, picks one 2-bit symbol from a
// 16-bit word, first symbol in the top bits. Depends on nothing.
`default_nettype none

module fsk4fb_dibit_sel (
	input  wire logic [15:0] word,
	input  wire logic [2:0]  idx,
	output logic [1:0]       dibit
);

	logic [3:0]  shamt;
	logic [15:0] shifted;

	// symbol i sits at bits 15-2i .. 14-2i: shift right by 2*(7-i)
	assign shamt   = {~idx, 1'b0};
	assign shifted = word >> shamt;
	assign dibit   = shifted[1:0];

endmodule

`default_nettype wire

[design/fsk4fb_seq.sv]
// fsk4fb_seq: frame sequencer; walks preamble, sync, length, payload and checksum
// one symbol per unstalled cycle via the dibit unit. Uses fsk4fb_pkg, fsk4fb_dibit_sel.
`default_nettype none

module fsk4fb_seq
	import fsk4fb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] sync_pattern,
	input  wire logic        in_accept,
	input  wire fsk4fb_in_t  in_word,
	output logic             busy,
	input  wire logic        out_stall,
	output logic             out_valid,
	output fsk4fb_out_t      out_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_PRE,
		ST_SYNC,
		ST_LEN,
		ST_BYTE,
		ST_SUM
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       byte_q;
	logic [7:0]       len_q;
	logic             last_q;
	logic [7:0]       sum_q;
	logic             dropped_q;

	logic [15:0] sel_word;
	logic [2:0]  sel_idx;
	logic [1:0]  sel_dibit;
	logic [1:0]  sym;
	logic        advance;
	logic        dibit_end;
	logic        sec_end;
	logic        run_end;

	fsk4fb_dibit_sel u_dibit (
		.word  (sel_word),
		.idx   (sel_idx),
		.dibit (sel_dibit)
	);

	always_comb begin
		sel_word = '0;
		sel_idx  = {1'b0, cnt_q[1:0]};
		sym      = sel_dibit;
		case (state_q)
			ST_PRE: begin
				sym = {2{cnt_q[0]}};
			end
			ST_SYNC: begin
				sel_word = sync_pattern;
				sel_idx  = cnt_q[2:0];
				if (cnt_q >= SYNC_IN_REG) begin
					sym = 2'd0;
				end
			end
			ST_LEN:  sel_word = {len_q, 8'h00};
			ST_BYTE: sel_word = {byte_q, 8'h00};
			ST_SUM:  sel_word = {sum_q, 8'h00};
			default: sym = 2'd0;
		endcase
	end

	// end of the current section, and last symbol of the current input word
	always_comb begin
		sec_end = 1'b0;
		run_end = 1'b0;
		case (state_q)
			ST_ERR:  run_end = 1'b1;
			ST_PRE:  sec_end = (cnt_q == PRE_LAST);
			ST_SYNC: sec_end = (cnt_q == SYNC_LAST);
			ST_LEN:  sec_end = dibit_end;
			ST_BYTE: begin
				sec_end = dibit_end;
				run_end = dibit_end && !last_q;
			end
			ST_SUM: begin
				sec_end = dibit_end;
				run_end = dibit_end;
			end
			default: sec_end = 1'b0;
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign advance   = busy && (!out_valid || !out_stall);
	assign dibit_end = (cnt_q == DIBIT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			sum_q     <= '0;
			dropped_q <= 1'b0;
			out_valid <= 1'b0;
			out_word  <= '0;
		end else begin
			// hold a stalled symbol, drop a taken one unless a new one replaces it
			out_valid <= advance || (out_valid && out_stall);
			if (in_accept) begin
				cnt_q  <= '0;
				byte_q <= in_word.payload_byte;
				last_q <= in_word.last_of_frame;
				len_q  <= in_word.payload_len;
				if (in_word.first_of_frame) begin
					sum_q <= '0;
					if (in_word.payload_len > MAX_LEN) begin
						dropped_q <= 1'b1;
						state_q   <= ST_ERR;
					end else begin
						dropped_q <= 1'b0;
						state_q   <= ST_PRE;
					end
				end else if (dropped_q) begin
					// swallow the rest of a rejected frame
					if (in_word.last_of_frame) begin
						dropped_q <= 1'b0;
					end
				end else begin
					state_q <= ST_BYTE;
				end
			end else if (advance) begin
				out_word <= '{symbol: sym, end_of_run: run_end,
					length_error: (state_q == ST_ERR)};
				cnt_q    <= sec_end ? '0 : cnt_q + CNT_W'(1);
				case (state_q)
					ST_ERR: begin
						state_q <= ST_IDLE;
					end
					ST_PRE: begin
						if (sec_end) begin
							state_q <= ST_SYNC;
						end
					end
					ST_SYNC: begin
						if (sec_end) begin
							state_q <= ST_LEN;
						end
					end
					ST_LEN: begin
						if (dibit_end) begin
							// empty frame: checksum of zero closes it
							state_q <= (len_q == 8'd0) ? ST_SUM : ST_BYTE;
						end
					end
					ST_BYTE: begin
						if (dibit_end) begin
							sum_q   <= sum_q + byte_q;
							state_q <= last_q ? ST_SUM : ST_IDLE;
						end
					end
					ST_SUM: begin
						if (dibit_end) begin
							sum_q   <= '0;
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

[design/fsk4_frame_symbol_builder.sv]
// fsk4_frame_symbol_builder: top level of the 4FSK frame symbol builder; holds the
// sync register and the ports. Uses fsk4fb_pkg and fsk4fb_seq.
`default_nettype none

// Turns payload bytes into 2-bit 4FSK symbols, one symbol per output word.
// The first word of a frame (first_of_frame high) sends a preamble of
// PREAMBLE_SYMBOLS alternating 0/3 symbols, the sync symbols from sync_pattern
// (first symbol in bits 15..14), the length byte as four dibits, and then its
// own payload byte. Every later word sends its byte as four dibits, most
// significant pair first; a word with last_of_frame also sends the 8-bit
// wrapping byte sum of the frame. A zero-length frame is one word that sends
// the header and a zero checksum; its byte is ignored. A length above
// MAX_PAYLOAD_BYTES gives one word with length_error set and symbol 0, and the
// remaining words of that frame, up to the one with last_of_frame, are dropped.
// end_of_run marks the last symbol caused by each input word.
// Timing: the sequencer makes one symbol per cycle unless the output stalls,
// with a single shared dibit extraction unit, so an input word holds in_stall
// high while its symbols go out (4 per payload byte, 4 more with the checksum,
// 28 more for the frame header, 1 for a length error), and output stalls hold
// it high longer. A dropped word raises no in_stall.
// The sync register may be written at any time through cfg_valid/cfg_ready
// (always ready) while the block is idle.

module fsk4_frame_symbol_builder
	import fsk4fb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire fsk4fb_in_t  in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output fsk4fb_out_t      out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic [15:0] sync_pattern_q;
	logic        busy;

	// hold the sync word; reset value gives 0,1,2,3,3,2,1,0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_pattern_q <= 16'h1BE4;
		end else if (cfg_valid && cfg_ready) begin
			sync_pattern_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;

	fsk4fb_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sync_pattern (sync_pattern_q),
		.in_accept    (in_valid && !busy),
		.in_word      (in_data),
		.busy         (busy),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_word     (out_data)
	);

endmodule

`default_nettype wire
